// File: hw/rtl/tgapsd_pkg.sv
package tgapsd_pkg;

    // Pixel formats as stored in the pixel_format register
    typedef enum logic [1:0] {
        FMT_RGB555 = 2'd0,
        FMT_BGR24  = 2'd1,
        FMT_BGRA32 = 2'd2,
        FMT_ALT32  = 2'd3
    } fmt_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_COMPRESSED   = 2'd0,
        REG_PIXEL_FORMAT = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } reg_idx_t;

    localparam int CFG_DATA_W  = 16;
    localparam int DONE_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] RUN_FLAG_MIN = 8'd128;
    localparam logic [7:0] RUN_BIAS     = 8'd127;
    localparam logic [4:0] FIELD_MASK   = 5'h1f;

    // One completed pixel, as handed from the front end to the formatter
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        fmt_t       fmt;
        logic [7:0] rep;
        logic       last;
    } pix_rec_t;

    // Zero dimension counts as one
    function automatic logic [CFG_DATA_W-1:0] dim_eff(input logic [CFG_DATA_W-1:0] d);
        return (d == '0) ? CFG_DATA_W'(1) : d;
    endfunction

endpackage

// File: hw/rtl/tgapsd_front.sv
module tgapsd_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [tgapsd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    output logic                               push_valid,
    input  logic                               push_ready,
    output tgapsd_pkg::pix_rec_t               push_rec
);
    import tgapsd_pkg::*;

    // Configuration
    logic                  compressed_reg;
    logic [1:0]            pixel_format_reg;
    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;
    logic [DONE_W-1:0]     total_reg, total_next;

    // Stream state
    logic [1:0]        byte_pos_reg, byte_pos_next;
    logic [7:0]        pix_b0_reg, pix_b1_reg, pix_b2_reg;
    logic [7:0]        pix_b0_next, pix_b1_next, pix_b2_next;
    logic [7:0]        remaining_reg, remaining_next;
    logic              is_run_reg, is_run_next;
    logic [DONE_W-1:0] done_reg, done_next;

    fmt_t              fmt_eff;
    logic [1:0]        pos_final;
    logic              rle;
    logic              accept;
    logic              is_header;
    logic              gather;
    logic [DONE_W-1:0] left;
    logic [7:0]        count;
    logic [7:0]        rep;
    logic [DONE_W-1:0] done_sum;
    logic              last;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    // Total pixel count, refreshed on a dimension write
    always_comb begin
        total_next = total_reg;
        if (cfg_wr_en && cfg_index == REG_IMAGE_WIDTH) begin
            total_next = dim_eff(cfg_data) * dim_eff(image_height_reg);
        end else if (cfg_wr_en && cfg_index == REG_IMAGE_HEIGHT) begin
            total_next = dim_eff(image_width_reg) * dim_eff(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compressed_reg   <= 1'b0;
            pixel_format_reg <= FMT_BGR24;
            image_width_reg  <= CFG_DATA_W'(1);
            image_height_reg <= CFG_DATA_W'(1);
            total_reg        <= DONE_W'(1);
        end else begin
            total_reg <= total_next;
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_index))
                    REG_COMPRESSED:   compressed_reg   <= cfg_data[0];
                    REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[1:0];
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Byte classification and packet bookkeeping
    always_comb begin
        case (fmt_t'(pixel_format_reg))
            FMT_RGB555: begin fmt_eff = FMT_RGB555; pos_final = 2'd1; end
            FMT_BGR24:  begin fmt_eff = FMT_BGR24;  pos_final = 2'd2; end
            default:    begin fmt_eff = FMT_BGRA32; pos_final = 2'd3; end
        endcase
        rle       = compressed_reg && (fmt_eff != FMT_RGB555);
        is_header = rle && (remaining_reg == 8'd0);
        gather    = !is_header && (byte_pos_reg < pos_final);

        // packet length, clamped to what is left of the image
        left  = (done_reg < total_reg) ? (total_reg - done_reg) : DONE_W'(1);
        count = (s_data_byte < RUN_FLAG_MIN) ? (s_data_byte + 8'd1)
                                             : (s_data_byte - RUN_BIAS);
        if (DONE_W'(count) > left) begin
            count = left[7:0];
        end

        rep      = (rle && is_run_reg) ? remaining_reg : 8'd1;
        done_sum = done_reg + DONE_W'(rep);
        last     = (done_sum >= total_reg);

        byte_pos_next  = byte_pos_reg;
        pix_b0_next    = pix_b0_reg;
        pix_b1_next    = pix_b1_reg;
        pix_b2_next    = pix_b2_reg;
        remaining_next = remaining_reg;
        is_run_next    = is_run_reg;
        done_next      = done_reg;

        if (accept) begin
            if (is_header) begin
                is_run_next    = (s_data_byte >= RUN_FLAG_MIN);
                remaining_next = count;
                byte_pos_next  = 2'd0;
            end else if (gather) begin
                case (byte_pos_reg)
                    2'd1:    pix_b1_next = s_data_byte;
                    2'd2:    pix_b2_next = s_data_byte;
                    default: pix_b0_next = s_data_byte;
                endcase
                byte_pos_next = byte_pos_reg + 2'd1;
            end else begin
                byte_pos_next = 2'd0;
                if (rle) begin
                    remaining_next = is_run_reg ? 8'd0 : (remaining_reg - 8'd1);
                end
                done_next = done_sum;
                if (last) begin
                    pix_b0_next    = 8'd0;
                    pix_b1_next    = 8'd0;
                    pix_b2_next    = 8'd0;
                    remaining_next = 8'd0;
                    is_run_next    = 1'b0;
                    done_next      = '0;
                end
            end
        end

        push_valid    = accept && !is_header && !gather;
        push_rec.b0   = pix_b0_reg;
        push_rec.b1   = pix_b1_reg;
        push_rec.b2   = pix_b2_reg;
        push_rec.b3   = s_data_byte;
        push_rec.fmt  = fmt_eff;
        push_rec.rep  = rep;
        push_rec.last = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg  <= 2'd0;
            pix_b0_reg    <= 8'd0;
            pix_b1_reg    <= 8'd0;
            pix_b2_reg    <= 8'd0;
            remaining_reg <= 8'd0;
            is_run_reg    <= 1'b0;
            done_reg      <= '0;
        end else begin
            byte_pos_reg  <= byte_pos_next;
            pix_b0_reg    <= pix_b0_next;
            pix_b1_reg    <= pix_b1_next;
            pix_b2_reg    <= pix_b2_next;
            remaining_reg <= remaining_next;
            is_run_reg    <= is_run_next;
            done_reg      <= done_next;
        end
    end

    // end of image must leave the stream state cleared
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid && push_rec.last |=> done_reg == '0 && remaining_reg == 8'd0
                                        && byte_pos_reg == 2'd0)
        else $error("stream state not cleared after last pixel");

    // a packet never holds more than one run's worth of pixels
    a_remaining_range: assert property (@(posedge aclk) disable iff (!aresetn)
        remaining_reg <= RUN_FLAG_MIN)
        else $error("packet count out of range");

endmodule

// File: hw/rtl/tgapsd_queue.sv
module tgapsd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  tgapsd_pkg::pix_rec_t push_rec,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output tgapsd_pkg::pix_rec_t pop_rec
);
    import tgapsd_pkg::*;

    pix_rec_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_rec    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy overflow");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step with occupancy");

endmodule

// File: hw/rtl/tgapsd_back.sv
module tgapsd_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  tgapsd_pkg::pix_rec_t pop_rec,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_red,
    output logic [7:0]           m_green,
    output logic [7:0]           m_blue,
    output logic [7:0]           m_alpha,
    output logic [7:0]           m_repeat_count,
    output logic                 m_last_pixel
);
    import tgapsd_pkg::*;

    logic        valid_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg, rep_reg;
    logic        last_reg;
    logic [7:0]  red_next, green_next, blue_next, alpha_next;
    logic [15:0] word16;

    assign pop_ready = !valid_reg || m_ready;

    // Color unpacking per format
    always_comb begin
        word16     = {pop_rec.b3, pop_rec.b0};
        alpha_next = 8'd0;
        case (pop_rec.fmt)
            FMT_RGB555: begin
                blue_next  = {word16[4:0] & FIELD_MASK, 3'b000};
                green_next = {word16[9:5] & FIELD_MASK, 3'b000};
                red_next   = {word16[14:10] & FIELD_MASK, 3'b000};
            end
            FMT_BGR24: begin
                blue_next  = pop_rec.b0;
                green_next = pop_rec.b1;
                red_next   = pop_rec.b3;
            end
            default: begin
                blue_next  = pop_rec.b0;
                green_next = pop_rec.b1;
                red_next   = pop_rec.b2;
                alpha_next = pop_rec.b3;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop_ready) begin
            valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ready && pop_valid) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= alpha_next;
            rep_reg   <= pop_rec.rep;
            last_reg  <= pop_rec.last;
        end
    end

    assign m_valid        = valid_reg;
    assign m_red          = red_reg;
    assign m_green        = green_reg;
    assign m_blue         = blue_reg;
    assign m_alpha        = alpha_reg;
    assign m_repeat_count = rep_reg;
    assign m_last_pixel   = last_reg;

endmodule

// File: hw/rtl/tga_pixel_stream_decoder_core.sv
// A pixel's last byte passes into the queue, then into the output register.
// Throughput: the front end takes one byte per cycle while the queue has room;
//   a pixel per 2 (16-bit), 3 or 4 bytes, plus a header per run-length packet.
// A two-entry queue and the output register absorb up to three pixels of stall.
// Reset: synchronous on aresetn low; config returns to raw 24-bit, 1x1 image,
//   and all stream state and queued pixels are cleared.
module tga_pixel_stream_decoder_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [1:0]                         cfg_index,
    input  logic [tgapsd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_red,
    output logic [7:0]                         m_green,
    output logic [7:0]                         m_blue,
    output logic [7:0]                         m_alpha,
    output logic [7:0]                         m_repeat_count,
    output logic                               m_last_pixel
);
    import tgapsd_pkg::*;

    logic     push_valid, push_ready;
    pix_rec_t push_rec;
    logic     pop_valid, pop_ready;
    pix_rec_t pop_rec;

    tgapsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_rec    (push_rec)
    );

    tgapsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    tgapsd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_rec        (pop_rec),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_alpha        (m_alpha),
        .m_repeat_count (m_repeat_count),
        .m_last_pixel   (m_last_pixel)
    );

endmodule

// File: sim/tb_top.sv
module tb_top;
    import tgapsd_pkg::*;

    // One decoded pixel as seen on the result channel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] rep;
        logic       last;
    } pixel_t;

    // One row of the directed table: a register write or a data beat
    typedef struct packed {
        logic       is_cfg;
        reg_idx_t   idx;
        logic [CFG_DATA_W-1:0] val;
        logic [7:0] data;
        logic       typed;
        pixel_t     px;
    } step_t;

    localparam int RANDOM_BYTES  = 1600;
    localparam int WATCHDOG_MAX  = 4000;
    localparam int SQUEEZE_LEN   = 300;
    localparam int SQUEEZE_PHASE = 7;
    localparam int CALM_PHASE    = 5;
    localparam int SETTLE_CYCLES = 4;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_red;
    logic [7:0]            m_green;
    logic [7:0]            m_blue;
    logic [7:0]            m_alpha;
    logic [7:0]            m_repeat_count;
    logic                  m_last_pixel;

    tga_pixel_stream_decoder_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_alpha        (m_alpha),
        .m_repeat_count (m_repeat_count),
        .m_last_pixel   (m_last_pixel)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow of the decoder: configuration and stream state
    logic                  cfg_comp;
    fmt_t                  cfg_fmt;
    logic [CFG_DATA_W-1:0] cfg_w;
    logic [CFG_DATA_W-1:0] cfg_h;
    logic [1:0]            pos;
    logic [7:0]            held [3];
    logic [7:0]            pkt_left;
    logic                  pkt_run;
    logic [31:0]           done_cnt;

    pixel_t pixel_q [$];
    int     errors = 0;
    int     n_bytes = 0;
    int     n_pixels = 0;
    int     n_images = 0;
    int     n_runs = 0;
    bit     calm = 1'b0;
    int     squeeze_req = 0;
    int     squeeze_seen = 0;
    int     hold = 0;
    int     quiet = 0;

    task automatic clear_stream();
        pos      = '0;
        held[0]  = '0;
        held[1]  = '0;
        held[2]  = '0;
        pkt_left = '0;
        pkt_run  = 1'b0;
        done_cnt = '0;
    endtask

    // Advance the shadow by one data byte; emitted is set when a pixel completes
    task automatic decode_byte(input logic [7:0] b, output bit emitted, output pixel_t px);
        fmt_t        f;
        int unsigned nbytes;
        bit          rle;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] total;
        logic [31:0] cnt;
        logic [31:0] left;
        logic [15:0] v;
        emitted = 1'b0;
        px      = '0;
        f       = (cfg_fmt == FMT_ALT32) ? FMT_BGRA32 : cfg_fmt;
        nbytes  = (f == FMT_RGB555) ? 2 : ((f == FMT_BGR24) ? 3 : 4);
        rle     = cfg_comp && (f != FMT_RGB555);
        w       = (cfg_w == 0) ? 32'd1 : 32'(cfg_w);
        h       = (cfg_h == 0) ? 32'd1 : 32'(cfg_h);
        total   = w * h;

        // packet header: count is clamped to what is left of the image
        if (rle && pkt_left == 0) begin
            pkt_run = b[7];
            cnt     = b[7] ? 32'(b) - 32'd127 : 32'(b) + 32'd1;
            left    = (done_cnt < total) ? total - done_cnt : 32'd1;
            if (cnt > left)
                cnt = left;
            pkt_left = cnt[7:0];
            pos      = '0;
            return;
        end

        if (int'(pos) + 1 < nbytes) begin
            held[pos] = b;
            pos       = pos + 2'd1;
            return;
        end
        pos = '0;

        case (f)
            FMT_RGB555: begin
                v        = {b, held[0]};
                px.blue  = {v[4:0], 3'b000};
                px.green = {v[9:5], 3'b000};
                px.red   = {v[14:10], 3'b000};
            end
            FMT_BGR24: begin
                px.blue  = held[0];
                px.green = held[1];
                px.red   = b;
            end
            default: begin
                px.blue  = held[0];
                px.green = held[1];
                px.red   = held[2];
                px.alpha = b;
            end
        endcase

        px.rep = 8'd1;
        if (rle) begin
            if (pkt_run) begin
                px.rep   = pkt_left;
                pkt_left = '0;
            end else begin
                pkt_left = pkt_left - 8'd1;
            end
        end
        done_cnt = done_cnt + 32'(px.rep);
        if (done_cnt >= total) begin
            px.last = 1'b1;
            clear_stream();
        end
        emitted = 1'b1;
    endtask

    // Offer one beat, hold it until taken, then maybe idle
    task automatic send_byte(input logic [7:0] b, input bit typed, input pixel_t lit);
        bit     got;
        pixel_t px;
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        n_bytes++;
        decode_byte(b, got, px);
        if (typed)
            pixel_q.push_back(lit);
        else if (got)
            pixel_q.push_back(px);
        if (!calm && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 18);
        end
    endtask

    // Register write, only once the decoder has drained
    task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        if (s_valid)
            s_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COMPRESSED:   cfg_comp = val[0];
            REG_PIXEL_FORMAT: cfg_fmt  = fmt_t'(val[1:0]);
            REG_IMAGE_WIDTH:  cfg_w    = val;
            default:          cfg_h    = val;
        endcase
    endtask

    function automatic step_t cfg_row(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        step_t s = '0;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.val    = val;
        return s;
    endfunction

    function automatic step_t byte_row(input logic [7:0] d);
        step_t s = '0;
        s.data = d;
        return s;
    endfunction

    function automatic step_t pixel_row(input logic [7:0] d, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] bl,
                                        input logic [7:0] a, input logic [7:0] rep,
                                        input logic last);
        step_t s = '0;
        s.data  = d;
        s.typed = 1'b1;
        s.px    = '{red: r, green: g, blue: bl, alpha: a, rep: rep, last: last};
        return s;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Result channel: compare each beat with the oldest expected pixel
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                $error("pixel beat with nothing expected");
                errors++;
            end else begin
                check_field("red", pixel_q[0].red, m_red);
                check_field("green", pixel_q[0].green, m_green);
                check_field("blue", pixel_q[0].blue, m_blue);
                check_field("alpha", pixel_q[0].alpha, m_alpha);
                check_field("repeat_count", pixel_q[0].rep, m_repeat_count);
                check_field("last_pixel", 8'(pixel_q[0].last), 8'(m_last_pixel));
                void'(pixel_q.pop_front());
            end
            n_pixels++;
            if (m_last_pixel)
                n_images++;
            if (m_repeat_count > 8'd1)
                n_runs++;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(posedge aclk) begin
        if (squeeze_req != squeeze_seen) begin
            squeeze_seen <= squeeze_req;
            hold         <= SQUEEZE_LEN;
            m_ready      <= 1'b0;
        end else if (hold != 0) begin
            hold    <= hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 18);
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WATCHDOG_MAX) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        step_t       plan [0:34];
        int          ph;
        int          n;
        int          rand_sent;
        int unsigned cnt;
        logic [7:0]  b;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        logic        comp;
        fmt_t        fmt;
        bit          rle_now;

        cfg_comp = 1'b0;
        cfg_fmt  = FMT_BGR24;
        cfg_w    = 16'd1;
        cfg_h    = 16'd1;
        clear_stream();

        plan = '{
            // reset config: raw 24-bit, 1x1 image
            byte_row(8'h11), byte_row(8'h22),
            pixel_row(8'h33, 8'h33, 8'h22, 8'h11, 8'h00, 8'd1, 1'b1),
            // 16-bit ignores the run-length flag; top bit of the word is dropped
            cfg_row(REG_COMPRESSED, 16'd1), cfg_row(REG_PIXEL_FORMAT, 16'(FMT_RGB555)),
            byte_row(8'hFF),
            pixel_row(8'h7F, 8'hF8, 8'hF8, 8'hF8, 8'h00, 8'd1, 1'b1),
            byte_row(8'h00),
            pixel_row(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1),
            // format code 3 behaves as 32-bit
            cfg_row(REG_COMPRESSED, 16'd0), cfg_row(REG_PIXEL_FORMAT, 16'(FMT_ALT32)),
            byte_row(8'h01), byte_row(8'h02), byte_row(8'h03),
            pixel_row(8'h04, 8'h03, 8'h02, 8'h01, 8'h04, 8'd1, 1'b1),
            // zero dimensions count as one; a 128 run is clamped to one pixel
            cfg_row(REG_COMPRESSED, 16'd1), cfg_row(REG_PIXEL_FORMAT, 16'(FMT_BGRA32)),
            cfg_row(REG_IMAGE_WIDTH, 16'd0), cfg_row(REG_IMAGE_HEIGHT, 16'd0),
            byte_row(8'hFF), byte_row(8'h10), byte_row(8'h20), byte_row(8'h30),
            pixel_row(8'h40, 8'h30, 8'h20, 8'h10, 8'h40, 8'd1, 1'b1),
            // largest image: full 128 run, then a raw packet left open
            cfg_row(REG_PIXEL_FORMAT, 16'(FMT_BGR24)),
            cfg_row(REG_IMAGE_WIDTH, 16'hFFFF), cfg_row(REG_IMAGE_HEIGHT, 16'hFFFF),
            byte_row(8'hFF), byte_row(8'h0A), byte_row(8'h0B),
            pixel_row(8'h0C, 8'h0C, 8'h0B, 8'h0A, 8'h00, 8'd128, 1'b0),
            byte_row(8'h7F), byte_row(8'h00), byte_row(8'h80), byte_row(8'hFF)
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                cfg_write(plan[i].idx, plan[i].val);
            else
                send_byte(plan[i].data, plan[i].typed, plan[i].px);
        end

        // random phases; state carries across config changes mid-image
        rand_sent = 0;
        ph        = 0;
        while (rand_sent < RANDOM_BYTES) begin
            case (ph % 6)
                2: begin
                    w = 16'hFFFF;
                    h = 16'hFFFF;
                end
                4: begin
                    w = 16'd0;
                    h = 16'($urandom_range(0, 1));
                end
                default: begin
                    w = 16'($urandom_range(1, 8));
                    h = 16'($urandom_range(1, 4));
                end
            endcase
            comp = 1'($urandom_range(0, 1));
            fmt  = fmt_t'(2'($urandom_range(0, 3)));
            if (ph == SQUEEZE_PHASE) begin
                comp = 1'b0;
                fmt  = FMT_RGB555;
            end
            cfg_write(REG_COMPRESSED, 16'(comp));
            cfg_write(REG_PIXEL_FORMAT, 16'(fmt));
            cfg_write(REG_IMAGE_WIDTH, w);
            cfg_write(REG_IMAGE_HEIGHT, h);
            calm = (ph == CALM_PHASE);
            if (ph == SQUEEZE_PHASE)
                squeeze_req++;

            n = $urandom_range(30, 110);
            repeat (n) begin
                rle_now = cfg_comp && (cfg_fmt != FMT_RGB555);
                if ($urandom_range(99) < 6) begin
                    b = 8'($urandom_range(0, 255));
                end else if (rle_now && pkt_left == 0) begin
                    cnt = ($urandom_range(9) == 0) ? $urandom_range(1, 128)
                                                   : $urandom_range(1, 6);
                    b = $urandom_range(0, 1) ? 8'(cnt + 127) : 8'(cnt - 1);
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                send_byte(b, 1'b0, '0);
                rand_sent++;
            end
            calm = 1'b0;
            ph++;
        end

        // drain and settle
        if (s_valid)
            s_valid <= 1'b0;
        n = 0;
        while (pixel_q.size() != 0 && n < WATCHDOG_MAX) begin
            @(posedge aclk);
            n++;
        end
        repeat (8) @(posedge aclk);
        if (pixel_q.size() != 0) begin
            $error("%0d expected pixels never arrived", pixel_q.size());
            errors++;
        end

        $display("Sent %0d bytes over %0d config phases in all formats, raw and run-length.",
                 n_bytes, ph);
        $display("Checked %0d pixel beats: %0d image ends, %0d runs; %0d errors.",
                 n_pixels, n_images, n_runs, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
